// File: hw/rtl/periodic_alarm_table_assert.svh
// Assertion macros for the periodic alarm table
`ifndef PERIODIC_ALARM_TABLE_ASSERT_SVH
`define PERIODIC_ALARM_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset
`define PAT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define PAT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/pat_pkg.sv
// Types, codes and constants shared by the periodic alarm table modules
`timescale 1ns / 1ps
package pat_pkg;

   localparam int TIME_W     = 40;
   localparam int CMD_W      = 2;
   localparam int KIND_W     = 3;
   localparam int ID_W       = 8;
   localparam int MINS_W     = 10;
   localparam int STATUS_W   = 3;
   localparam int SSTATE_W   = 2;
   localparam int FIRED_W    = 5;
   localparam int MAX_OUT    = 16;
   localparam int INTERVAL_W = 22;
   localparam int PROD_W     = 16;

   localparam logic [TIME_W-1:0]     TIME_MAX   = '1;
   localparam logic [INTERVAL_W-1:0] DAY_SEC    = 22'd86400;
   localparam logic [INTERVAL_W-1:0] WEEK_SEC   = 22'd604800;
   localparam logic [INTERVAL_W-1:0] MONTH_SEC  = 22'd2592000;
   localparam logic [PROD_W-1:0]     SNOOZE_SEC = 16'd60;

   // commands
   localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SNOOZE = 2'd3;

   // result status
   localparam logic [STATUS_W-1:0] RS_FIRED      = 3'd0;
   localparam logic [STATUS_W-1:0] RS_NONE_DUE   = 3'd1;
   localparam logic [STATUS_W-1:0] RS_ADDED      = 3'd2;
   localparam logic [STATUS_W-1:0] RS_DONE       = 3'd3;
   localparam logic [STATUS_W-1:0] RS_NOT_FOUND  = 3'd4;
   localparam logic [STATUS_W-1:0] RS_TABLE_FULL = 3'd5;

   // slot states
   localparam logic [SSTATE_W-1:0] SS_ACTIVE    = 2'd0;
   localparam logic [SSTATE_W-1:0] SS_TRIGGERED = 2'd1;
   localparam logic [SSTATE_W-1:0] SS_CANCELLED = 2'd2;

   // repeat kinds with their own interval; other nonzero kinds repeat daily
   localparam logic [KIND_W-1:0] KIND_ONCE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WEEKLY  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MONTHLY = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0]   alarm_time;
      logic [KIND_W-1:0]   repeat_kind;
      logic [SSTATE_W-1:0] slot_state;
   } slot_type;

   function automatic logic [INTERVAL_W-1:0] interval_of(input logic [KIND_W-1:0] kind);
      logic [INTERVAL_W-1:0] ival;
      case (kind)
         KIND_WEEKLY:  ival = WEEK_SEC;
         KIND_MONTHLY: ival = MONTH_SEC;
         default:      ival = DAY_SEC;
      endcase
      return ival;
   endfunction

endpackage

// File: hw/rtl/pat_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module pat_ram #(
   parameter int WIDTH = 45,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pat_slot_upd.sv
// Slot update logic: due test, saturating re-arm, cancel and snooze
`timescale 1ns / 1ps
module pat_slot_upd import pat_pkg::*; (
   input  logic [CMD_W-1:0]  cmd,
   input  logic [TIME_W-1:0] now_seconds,
   input  logic [MINS_W-1:0] snooze_minutes,
   input  slot_type          cur,
   output slot_type          nxt,
   output logic              due
);

   logic [PROD_W-1:0] snooze_sec;
   logic [TIME_W:0]   rearm_sum;
   logic [TIME_W:0]   snooze_sum;
   logic [TIME_W-1:0] rearm_time;
   logic [TIME_W-1:0] snooze_time;

   assign due = (cur.slot_state == SS_ACTIVE) && (now_seconds >= cur.alarm_time);

   assign rearm_sum  = {1'b0, cur.alarm_time} + (TIME_W+1)'(interval_of(cur.repeat_kind));
   assign rearm_time = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];

   assign snooze_sec  = PROD_W'(snooze_minutes) * SNOOZE_SEC;
   assign snooze_sum  = {1'b0, now_seconds} + (TIME_W+1)'(snooze_sec);
   assign snooze_time = snooze_sum[TIME_W] ? TIME_MAX : snooze_sum[TIME_W-1:0];

   always_comb begin
      nxt = cur;
      case (cmd)
         CMD_CHECK: begin
            if (cur.repeat_kind == KIND_ONCE) begin
               nxt.slot_state = SS_TRIGGERED;
            end else begin
               nxt.alarm_time = rearm_time;
            end
         end
         CMD_CANCEL: begin
            nxt.slot_state = SS_CANCELLED;
         end
         CMD_SNOOZE: begin
            nxt.alarm_time = snooze_time;
            nxt.slot_state = SS_ACTIVE;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// File: hw/rtl/periodic_alarm_table.sv
// Periodic alarm table top level: command sequencer around the slot RAM
`timescale 1ns / 1ps
`include "periodic_alarm_table_assert.svh"
// The block keeps NUM_SLOTS alarm slots (trigger time, repeat kind, state) in
// one synchronous RAM and serves one command at a time. Add loads its result
// from the decode state; cancel and snooze do a read, then a write back, and
// a check visits each of the N slots in use, first reading it from the RAM
// and then testing it and writing it back. The next command is taken in the
// cycle after the last result of the previous one has been loaded into the
// output register. Ids are slot number plus one; a check reports at most 16
// fired slots and always ends with a result that has last set. Stalls on the
// result side hold the sequencer without losing work.
module periodic_alarm_table import pat_pkg::*; #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [TIME_W-1:0]   req_now_seconds,
   input  logic [TIME_W-1:0]   req_alarm_time,
   input  logic [KIND_W-1:0]   req_repeat_kind,
   input  logic [ID_W-1:0]     req_alarm_id,
   input  logic [MINS_W-1:0]   req_snooze_minutes,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ID_W-1:0]     rsp_result_id,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   // slot index width and a count wide enough to hold NUM_SLOTS itself
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a command
   localparam logic [2:0] S_DISP   = 3'd1;  // decode latched command
   localparam logic [2:0] S_OPEV   = 3'd2;  // cancel/snooze write back
   localparam logic [2:0] S_CHKRD  = 3'd3;  // check: issue slot read
   localparam logic [2:0] S_CHKEV  = 3'd4;  // check: test and write back
   localparam logic [2:0] S_CHKEND = 3'd5;  // check: final result

   logic [2:0]          state_ff, state_in;

   // latched command
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [TIME_W-1:0]   atime_ff, atime_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [MINS_W-1:0]   mins_ff, mins_in;

   // table and scan state
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [FIRED_W-1:0]  fired_ff, fired_in;
   logic                pend_ff, pend_in;       // a fired id waits for its last flag
   logic [ID_W-1:0]     pend_id_ff, pend_id_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // result staging from the sequencer
   logic                load_out;
   logic [ID_W-1:0]     out_id;
   logic [STATUS_W-1:0] out_status;
   logic                out_last;
   logic                out_free;

   // RAM ports
   logic                mem_we;
   logic [SLOT_W-1:0]   mem_waddr;
   slot_type            mem_wdata;
   logic                mem_re;
   logic [SLOT_W-1:0]   mem_raddr;
   slot_type            mem_rdata;

   slot_type            upd_slot;
   logic                upd_due;
   logic [ID_W-1:0]     id_m1;

   assign id_m1     = id_ff - ID_W'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   pat_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pat_slot_upd u_slot_upd (
      .cmd            (cmd_ff),
      .now_seconds    (now_ff),
      .snooze_minutes (mins_ff),
      .cur            (mem_rdata),
      .nxt            (upd_slot),
      .due            (upd_due)
   );

   // Sequencer. A slot is only read in a state that precedes its write back,
   // and the next read waits until that write is done, so reads and writes
   // of the same entry never overlap.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      now_in     = now_ff;
      atime_in   = atime_ff;
      kind_in    = kind_ff;
      id_in      = id_ff;
      mins_in    = mins_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      fired_in   = fired_ff;
      pend_in    = pend_ff;
      pend_id_in = pend_id_ff;

      load_out   = 1'b0;
      out_id     = '0;
      out_status = RS_DONE;
      out_last   = 1'b1;

      mem_we     = 1'b0;
      mem_waddr  = idx_ff[SLOT_W-1:0];
      mem_wdata  = upd_slot;
      mem_re     = 1'b0;
      mem_raddr  = idx_ff[SLOT_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               now_in   = req_now_seconds;
               atime_in = req_alarm_time;
               kind_in  = req_repeat_kind;
               id_in    = req_alarm_id;
               mins_in  = req_snooze_minutes;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (cmd_ff)
               CMD_CHECK: begin
                  idx_in   = '0;
                  fired_in = '0;
                  pend_in  = 1'b0;
                  state_in = S_CHKRD;
               end
               CMD_ADD: begin
                  if (out_free) begin
                     load_out = 1'b1;
                     state_in = S_IDLE;
                     if (count_ff == CNT_W'(NUM_SLOTS)) begin
                        out_status = RS_TABLE_FULL;
                     end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_ff[SLOT_W-1:0];
                        mem_wdata  = '{alarm_time: atime_ff, repeat_kind: kind_ff,
                                       slot_state: SS_ACTIVE};
                        count_in   = count_ff + CNT_W'(1);
                        out_id     = ID_W'(count_ff) + ID_W'(1);
                        out_status = RS_ADDED;
                     end
                  end
               end
               default: begin
                  // cancel and snooze: id must name a slot in use
                  if (id_ff == '0 || id_ff > ID_W'(count_ff)) begin
                     if (out_free) begin
                        load_out   = 1'b1;
                        out_status = RS_NOT_FOUND;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = id_m1[SLOT_W-1:0];
                     state_in  = S_OPEV;
                  end
               end
            endcase
         end
         S_OPEV: begin
            if (out_free) begin
               mem_we     = 1'b1;
               mem_waddr  = id_m1[SLOT_W-1:0];
               load_out   = 1'b1;
               out_status = RS_DONE;
               state_in   = S_IDLE;
            end
         end
         S_CHKRD: begin
            if (idx_ff >= count_ff || fired_ff == FIRED_W'(MAX_OUT)) begin
               state_in = S_CHKEND;
            end else begin
               mem_re   = 1'b1;
               state_in = S_CHKEV;
            end
         end
         S_CHKEV: begin
            if (!upd_due) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_CHKRD;
            end else if (!pend_ff || out_free) begin
               // earlier fired id goes out now: a later one follows it
               mem_we     = 1'b1;
               load_out   = pend_ff;
               out_id     = pend_id_ff;
               out_status = RS_FIRED;
               out_last   = 1'b0;
               pend_in    = 1'b1;
               pend_id_in = ID_W'(idx_ff) + ID_W'(1);
               fired_in   = fired_ff + FIRED_W'(1);
               idx_in     = idx_ff + CNT_W'(1);
               state_in   = S_CHKRD;
            end
         end
         S_CHKEND: begin
            if (out_free) begin
               load_out   = 1'b1;
               out_id     = pend_ff ? pend_id_ff : '0;
               out_status = pend_ff ? RS_FIRED : RS_NONE_DUE;
               out_last   = 1'b1;
               pend_in    = 1'b0;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register: loads when empty or when its transfer completes
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_id_in     = out_id;
         rsp_status_in = out_status;
         rsp_last_in   = out_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         fired_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         fired_ff     <= fired_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      now_ff        <= now_in;
      atime_ff      <= atime_in;
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      mins_ff       <= mins_in;
      pend_id_ff    <= pend_id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   `PAT_ASSERT_NOW(a_count_range, 1'b1, count_ff <= CNT_W'(NUM_SLOTS), "slot count overflow")
   `PAT_ASSERT_NOW(a_fired_range, 1'b1, fired_ff <= FIRED_W'(MAX_OUT), "fired count overflow")
   `PAT_ASSERT_NOW(a_write_busy, mem_we, state_ff != S_IDLE, "slot write while idle")
   `PAT_ASSERT_NEXT(a_last_idle, load_out && out_last, state_ff == S_IDLE, "last result not idle")

endmodule
